/* src/lsdk_pkg.sv */
// Shared types and constants for the longest divisible subarray block.
// Used by lsdk_mod, lsdk_table and longest_subarray_sum_div_k; depends on nothing.
package lsdk_pkg;

    localparam int MODULUS_MAX = 1024;
    localparam int LENGTH_MAX  = 65536;

    localparam int VALUE_W  = 32;
    localparam int RES_W    = $clog2(MODULUS_MAX);
    localparam int MOD_W    = RES_W + 1;
    localparam int IDX_W    = $clog2(LENGTH_MAX);
    localparam int LEN_W    = IDX_W + 1;
    localparam int EPOCH_W  = 8;

    // Serial remainder unit: quotient bits retired per cycle and steps per pass.
    localparam int BITS_PER_STEP = 4;
    localparam int MOD_STEPS     = VALUE_W / BITS_PER_STEP;
    localparam int STEP_CNT_W    = $clog2(MOD_STEPS);

    localparam int OUT_DATA_W = LEN_W + 1;
    localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_TDATA_W - OUT_DATA_W;

    // One table entry: the array epoch in which it was written and the first index.
    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [IDX_W-1:0]   first_index;
    } entry_t;

    typedef struct packed {
        logic              wr_en;
        logic [RES_W-1:0]  addr;
        entry_t            wdata;
    } tbl_req_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD_VAL,
        ST_MOD_SUM,
        ST_LOOKUP,
        ST_UPDATE,
        ST_EMIT
    } state_t;

endpackage

/* src/lsdk_mod.sv */
// Serial remainder unit: dividend mod k, several quotient bits per cycle.
// Depends on lsdk_pkg.
module lsdk_mod
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [lsdk_pkg::VALUE_W-1:0]   dividend,
    input  logic [lsdk_pkg::MOD_W-1:0]     k,
    output logic                           done,
    output logic [lsdk_pkg::RES_W-1:0]     rem
);

    logic [lsdk_pkg::VALUE_W-1:0]    dvd_reg, dvd_next;
    logic [lsdk_pkg::RES_W-1:0]      rem_reg, rem_next;
    logic [lsdk_pkg::MOD_W-1:0]      k_reg, k_next;
    logic [lsdk_pkg::STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [lsdk_pkg::RES_W-1:0]      rem_step;

    // Restoring remainder: shift in one dividend bit, subtract k when it fits.
    always_comb
    begin
        logic [lsdk_pkg::MOD_W-1:0] acc;
        logic [lsdk_pkg::MOD_W-1:0] t;
        acc = {1'b0, rem_reg};
        for (int s = 0; s < lsdk_pkg::BITS_PER_STEP; s++)
        begin
            t = {acc[lsdk_pkg::RES_W-1:0], dvd_reg[lsdk_pkg::VALUE_W-1-s]};
            acc = (t >= k_reg) ? (t - k_reg) : t;
        end
        rem_step = acc[lsdk_pkg::RES_W-1:0];
    end

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        k_next    = k_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            k_next    = k;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_reg << lsdk_pkg::BITS_PER_STEP;
            rem_next = rem_step;
            cnt_next = cnt_reg + lsdk_pkg::STEP_CNT_W'(1);
            if (cnt_reg == lsdk_pkg::STEP_CNT_W'(lsdk_pkg::MOD_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        k_reg   <= k_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    a_rem_below_k: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ({1'b0, rem_reg} < k_reg))
        else $error("remainder not below the divisor");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (busy_reg && !done_reg))
        else $error("remainder unit did not start");

    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start
         && cnt_reg == lsdk_pkg::STEP_CNT_W'(lsdk_pkg::MOD_STEPS - 1))
        |=> (done_reg && !busy_reg))
        else $error("remainder unit did not finish on the last step");

endmodule

/* src/lsdk_table.sv */
// Residue table: one synchronous RAM holding epoch tag and first index per residue.
// Depends on lsdk_pkg.
module lsdk_table
(
    input  logic               clk,
    input  lsdk_pkg::tbl_req_t req,
    output lsdk_pkg::entry_t   rd_data
);

    lsdk_pkg::entry_t mem [lsdk_pkg::MODULUS_MAX];
    lsdk_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        rd_data_reg <= mem[req.addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/longest_subarray_sum_div_k.sv */
// Top level of the longest divisible subarray block: control, state and output register.
// Depends on lsdk_pkg, lsdk_mod and lsdk_table.
//
// The block takes one array as a stream of signed 32-bit elements on the slave side, the
// final element marked by tlast, and after that element delivers one transfer on the
// master side: the length of the longest run of consecutive elements whose sum is
// divisible by the configured modulus (1 to 1024; 0 acts as 1, larger values as 1024),
// and a flag that is set when the array held more than 65536 elements. A new element is
// taken only once the previous one is done, and after an array's last element only once
// the previous result is taken. Each element runs two passes of the serial remainder
// unit, which retires four bits a cycle, then one read and at most one write of the
// residue table RAM. After reset, and again after every 255th array, a clearing pass
// sweeps all 1024 table entries, during which no element is accepted. The modulus must
// stay constant over an array for the result to be meaningful.
module longest_subarray_sum_div_k
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [lsdk_pkg::MOD_W-1:0]          cfg_wr_data,    // modulus
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lsdk_pkg::VALUE_W-1:0]        s_axis_tdata,   // value (signed)
    input  logic                                s_axis_tlast,   // last_item
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [lsdk_pkg::OUT_TDATA_W-1:0]    m_axis_tdata    // longest_length, length_overflow
);

    lsdk_pkg::state_t              state_reg, state_next;
    logic [lsdk_pkg::MOD_W-1:0]    modulus_reg, modulus_next;
    logic [lsdk_pkg::MOD_W-1:0]    k_reg, k_next;
    logic                          neg_reg, neg_next;
    logic                          last_reg, last_next;
    logic [lsdk_pkg::IDX_W-1:0]    i_reg, i_next;
    logic [lsdk_pkg::RES_W-1:0]    res_reg, res_next;
    logic [lsdk_pkg::RES_W-1:0]    running_reg, running_next;
    logic [lsdk_pkg::LEN_W-1:0]    item_index_reg, item_index_next;
    logic [lsdk_pkg::LEN_W-1:0]    best_length_reg, best_length_next;
    logic                          overflow_reg, overflow_next;
    logic [lsdk_pkg::EPOCH_W-1:0]  epoch_reg, epoch_next;
    logic [lsdk_pkg::RES_W-1:0]    clear_cnt_reg, clear_cnt_next;
    logic                          out_valid_reg, out_valid_next;
    logic [lsdk_pkg::LEN_W-1:0]    out_length_reg, out_length_next;
    logic                          out_overflow_reg, out_overflow_next;

    logic                          in_xfer;
    logic                          out_load;
    logic [lsdk_pkg::MOD_W-1:0]    k_eff;
    logic                          in_neg;
    logic [lsdk_pkg::VALUE_W-1:0]  in_mag;
    logic [lsdk_pkg::MOD_W-1:0]    vres;
    logic [lsdk_pkg::MOD_W-1:0]    sum;
    logic [lsdk_pkg::IDX_W-1:0]    span;
    logic                          mod_start;
    logic [lsdk_pkg::VALUE_W-1:0]  mod_dividend;
    logic [lsdk_pkg::MOD_W-1:0]    mod_k;
    logic                          mod_done;
    logic [lsdk_pkg::RES_W-1:0]    mod_rem;
    lsdk_pkg::tbl_req_t            tbl_req;
    lsdk_pkg::entry_t              tbl_rd;
    logic                          entry_seen;

    lsdk_mod u_mod
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (mod_dividend),
        .k        (mod_k),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    lsdk_table u_table
    (
        .clk     (clk),
        .req     (tbl_req),
        .rd_data (tbl_rd)
    );

    always_comb
    begin
        if (modulus_reg == '0)
        begin
            k_eff = lsdk_pkg::MOD_W'(1);
        end
        else if (modulus_reg > lsdk_pkg::MOD_W'(lsdk_pkg::MODULUS_MAX))
        begin
            k_eff = lsdk_pkg::MOD_W'(lsdk_pkg::MODULUS_MAX);
        end
        else
        begin
            k_eff = modulus_reg;
        end
    end

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign in_neg   = s_axis_tdata[lsdk_pkg::VALUE_W-1];
    assign in_mag   = in_neg ? (lsdk_pkg::VALUE_W'(0) - s_axis_tdata) : s_axis_tdata;
    assign out_load = (state_reg == lsdk_pkg::ST_EMIT) && (!out_valid_reg || m_axis_tready);

    // A negative element contributes k minus the remainder of its magnitude, or zero when that remainder is zero.
    assign vres = (neg_reg && mod_rem != '0) ? (k_reg - {1'b0, mod_rem}) : {1'b0, mod_rem};
    assign sum  = {1'b0, running_reg} + vres;

    assign entry_seen = (tbl_rd.epoch == epoch_reg);
    assign span       = i_reg - tbl_rd.first_index;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lsdk_pkg::ST_CLEAR:
            begin
                if (clear_cnt_reg == {lsdk_pkg::RES_W{1'b1}})
                begin
                    state_next = lsdk_pkg::ST_IDLE;
                end
            end
            lsdk_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = lsdk_pkg::ST_MOD_VAL;
                end
            end
            lsdk_pkg::ST_MOD_VAL:
            begin
                if (mod_done)
                begin
                    state_next = lsdk_pkg::ST_MOD_SUM;
                end
            end
            lsdk_pkg::ST_MOD_SUM:
            begin
                if (mod_done)
                begin
                    state_next = lsdk_pkg::ST_LOOKUP;
                end
            end
            lsdk_pkg::ST_LOOKUP:
            begin
                state_next = lsdk_pkg::ST_UPDATE;
            end
            lsdk_pkg::ST_UPDATE:
            begin
                state_next = last_reg ? lsdk_pkg::ST_EMIT : lsdk_pkg::ST_IDLE;
            end
            lsdk_pkg::ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = (epoch_reg == {lsdk_pkg::EPOCH_W{1'b1}})
                               ? lsdk_pkg::ST_CLEAR : lsdk_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lsdk_pkg::ST_CLEAR;
            end
        endcase
    end

    // Outputs toward the handshake, the remainder unit and the table
    always_comb
    begin
        s_axis_tready = 1'b0;
        mod_start     = 1'b0;
        mod_dividend  = lsdk_pkg::VALUE_W'(sum);
        mod_k         = k_reg;
        tbl_req.wr_en = 1'b0;
        tbl_req.addr  = res_reg;
        tbl_req.wdata = '{epoch: epoch_reg, first_index: i_reg};
        case (state_reg)
            lsdk_pkg::ST_CLEAR:
            begin
                tbl_req.wr_en = 1'b1;
                tbl_req.addr  = clear_cnt_reg;
                tbl_req.wdata = '0;
            end
            lsdk_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                mod_start     = in_xfer;
                mod_dividend  = in_mag;
                mod_k         = k_eff;
            end
            lsdk_pkg::ST_MOD_VAL:
            begin
                mod_start = mod_done;
            end
            lsdk_pkg::ST_UPDATE:
            begin
                tbl_req.wr_en = (res_reg != '0) && !entry_seen;
            end
            default:
            begin
            end
        endcase
    end

    // Datapath registers
    always_comb
    begin
        modulus_next      = cfg_wr_en ? cfg_wr_data : modulus_reg;
        k_next            = k_reg;
        neg_next          = neg_reg;
        last_next         = last_reg;
        i_next            = i_reg;
        res_next          = res_reg;
        running_next      = running_reg;
        item_index_next   = item_index_reg;
        best_length_next  = best_length_reg;
        overflow_next     = overflow_reg;
        epoch_next        = epoch_reg;
        clear_cnt_next    = clear_cnt_reg;
        out_length_next   = out_length_reg;
        out_overflow_next = out_overflow_reg;
        out_valid_next    = out_valid_reg && !m_axis_tready;

        case (state_reg)
            lsdk_pkg::ST_CLEAR:
            begin
                clear_cnt_next = clear_cnt_reg + lsdk_pkg::RES_W'(1);
                if (clear_cnt_reg == {lsdk_pkg::RES_W{1'b1}})
                begin
                    epoch_next = lsdk_pkg::EPOCH_W'(1);
                end
            end
            lsdk_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    k_next    = k_eff;
                    neg_next  = in_neg;
                    last_next = s_axis_tlast;
                    if (item_index_reg >= lsdk_pkg::LEN_W'(lsdk_pkg::LENGTH_MAX))
                    begin
                        // Saturated: further items reuse the last index.
                        overflow_next = 1'b1;
                        i_next        = lsdk_pkg::IDX_W'(lsdk_pkg::LENGTH_MAX - 1);
                    end
                    else
                    begin
                        i_next          = item_index_reg[lsdk_pkg::IDX_W-1:0];
                        item_index_next = item_index_reg + lsdk_pkg::LEN_W'(1);
                    end
                end
            end
            lsdk_pkg::ST_MOD_SUM:
            begin
                if (mod_done)
                begin
                    res_next     = mod_rem;
                    running_next = mod_rem;
                end
            end
            lsdk_pkg::ST_UPDATE:
            begin
                if (res_reg == '0)
                begin
                    best_length_next = {1'b0, i_reg} + lsdk_pkg::LEN_W'(1);
                end
                else if (entry_seen && i_reg >= tbl_rd.first_index
                         && {1'b0, span} > best_length_reg)
                begin
                    best_length_next = {1'b0, span};
                end
            end
            lsdk_pkg::ST_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next    = 1'b1;
                    out_length_next   = best_length_reg;
                    out_overflow_next = overflow_reg;
                    running_next      = '0;
                    item_index_next   = '0;
                    best_length_next  = '0;
                    overflow_next     = 1'b0;
                    // A new epoch retires every entry of the finished array.
                    epoch_next        = epoch_reg + lsdk_pkg::EPOCH_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= lsdk_pkg::ST_CLEAR;
            modulus_reg     <= lsdk_pkg::MOD_W'(1);
            running_reg     <= '0;
            item_index_reg  <= '0;
            best_length_reg <= '0;
            overflow_reg    <= 1'b0;
            epoch_reg       <= '0;
            clear_cnt_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            modulus_reg     <= modulus_next;
            running_reg     <= running_next;
            item_index_reg  <= item_index_next;
            best_length_reg <= best_length_next;
            overflow_reg    <= overflow_next;
            epoch_reg       <= epoch_next;
            clear_cnt_reg   <= clear_cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg            <= k_next;
        neg_reg          <= neg_next;
        last_reg         <= last_next;
        i_reg            <= i_next;
        res_reg          <= res_next;
        out_length_reg   <= out_length_next;
        out_overflow_reg <= out_overflow_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{lsdk_pkg::OUT_PAD_W{1'b0}}, out_overflow_reg, out_length_reg};

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !s_axis_tready)
        else $error("input taken while an element is still in progress");

    a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != lsdk_pkg::ST_CLEAR) |-> (epoch_reg != '0))
        else $error("epoch zero outside the clearing pass");

    a_best_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lsdk_pkg::ST_IDLE) |-> (best_length_reg <= item_index_reg))
        else $error("best length exceeds the number of elements");

    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_req.wr_en |-> (state_reg == lsdk_pkg::ST_CLEAR
                           || state_reg == lsdk_pkg::ST_UPDATE))
        else $error("table written outside clear or update");

endmodule

/* sim/tb_longest_subarray_sum_div_k.sv */
`timescale 1ns / 1ps
// Testbench for longest_subarray_sum_div_k: streams signed arrays under many moduli and
// checks every length and overflow result against a predictor kept inside the bench.
// Depends on lsdk_pkg and the RTL of the block.
module tb_longest_subarray_sum_div_k;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 4;
    localparam int MAX_GAP        = 14;
    localparam int SETTLE_CYCLES  = 40;
    localparam int TAIL_CYCLES    = 60;
    localparam int HOLD_CYCLES    = 2000;
    localparam int WATCHDOG_LIMIT = 10000;
    localparam int RANDOM_ITEMS   = 980;

    typedef struct packed {
        logic [lsdk_pkg::VALUE_W-1:0] value;
        logic                         last;
    } element_t;

    typedef struct packed {
        logic [lsdk_pkg::LEN_W-1:0] length;
        logic                       overflow;
    } span_t;

    typedef enum int { VK_FULL, VK_SMALL, VK_MULTIPLE, VK_EDGE } value_kind_t;

    logic                             clk           = 1'b0;
    logic                             rst_n         = 1'b0;
    logic                             cfg_wr_en     = 1'b0;
    logic [lsdk_pkg::MOD_W-1:0]       cfg_wr_data   = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [lsdk_pkg::VALUE_W-1:0]     s_axis_tdata  = '0;   // value (signed)
    logic                             s_axis_tlast  = 1'b0; // last_item
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [lsdk_pkg::OUT_TDATA_W-1:0] m_axis_tdata;         // longest_length, length_overflow

    element_t pending_q[$];
    span_t    expected_spans[$];

    bit in_xfer     = 1'b0;
    bit out_xfer    = 1'b0;
    bit src_idle_on = 1'b1;
    bit snk_idle_on = 1'b1;
    bit hold_req    = 1'b0;
    bit snk_drawn   = 1'b0;
    int src_gap     = 0;
    int snk_wait    = 0;
    int hold_left   = 0;

    int mismatches      = 0;
    int results_checked = 0;
    int elements_taken  = 0;
    int arrays_queued   = 0;
    int modulus_writes  = 0;
    int idle_cycles     = 0;

    // Predictor state for the array in progress.
    logic [lsdk_pkg::MOD_W-1:0] mod_reg  = lsdk_pkg::MOD_W'(1);
    logic [lsdk_pkg::RES_W-1:0] acc_res  = '0;
    logic [lsdk_pkg::LEN_W-1:0] elem_idx = '0;
    logic [lsdk_pkg::LEN_W-1:0] best_len = '0;
    bit                         ovf      = 1'b0;
    logic [lsdk_pkg::IDX_W-1:0] first_at [lsdk_pkg::MODULUS_MAX];
    bit                         seen     [lsdk_pkg::MODULUS_MAX];

    longest_subarray_sum_div_k u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    function automatic int unsigned eff_modulus();
        if (mod_reg == 0)
            return 1;
        if (mod_reg > lsdk_pkg::MODULUS_MAX)
            return lsdk_pkg::MODULUS_MAX;
        return mod_reg;
    endfunction

    function automatic void clear_array();
        acc_res  = '0;
        elem_idx = '0;
        best_len = '0;
        ovf      = 1'b0;
        foreach (seen[r])
        begin
            seen[r]     = 1'b0;
            first_at[r] = '0;
        end
    endfunction

    function automatic void fold_element(input logic [lsdk_pkg::VALUE_W-1:0] value,
                                         input logic last);
        longint      k;
        longint      vres;
        longint      sum_res;
        int unsigned pos;
        int unsigned f;
        span_t       result;
        k    = eff_modulus();
        vres = $signed(value) % k;
        if (vres < 0)
            vres = vres + k;
        // Past the length bound the index sticks at its last position.
        if (elem_idx >= lsdk_pkg::LENGTH_MAX)
        begin
            ovf      = 1'b1;
            elem_idx = lsdk_pkg::LEN_W'(lsdk_pkg::LENGTH_MAX);
            pos      = lsdk_pkg::LENGTH_MAX - 1;
        end
        else
        begin
            pos      = elem_idx;
            elem_idx = elem_idx + 1'b1;
        end
        sum_res = (longint'(acc_res) + vres) % k;
        acc_res = lsdk_pkg::RES_W'(sum_res);
        if (sum_res == 0)
            best_len = lsdk_pkg::LEN_W'(pos + 1);
        else if (!seen[sum_res])
        begin
            seen[sum_res]     = 1'b1;
            first_at[sum_res] = pos[lsdk_pkg::IDX_W-1:0];
        end
        else
        begin
            f = first_at[sum_res];
            if (pos >= f && pos - f > best_len)
                best_len = lsdk_pkg::LEN_W'(pos - f);
        end
        if (last)
        begin
            result.length   = best_len;
            result.overflow = ovf;
            expected_spans.push_back(result);
            clear_array();
        end
    endfunction

    // Monitor, predictor and watchdog, all on the rising edge.
    always @(posedge clk)
    begin
        span_t                      want;
        logic [lsdk_pkg::LEN_W-1:0] got_len;
        logic                       got_ovf;
        in_xfer  = rst_n && s_axis_tvalid && s_axis_tready;
        out_xfer = rst_n && m_axis_tvalid && m_axis_tready;
        if (in_xfer)
        begin
            fold_element(s_axis_tdata, s_axis_tlast);
            elements_taken++;
        end
        if (out_xfer)
        begin
            got_len = m_axis_tdata[lsdk_pkg::LEN_W-1:0];
            got_ovf = m_axis_tdata[lsdk_pkg::LEN_W];
            if (expected_spans.size() == 0)
                report_mismatch("result with nothing expected", got_len, -1);
            else
            begin
                want = expected_spans.pop_front();
                results_checked++;
                if (got_len !== want.length)
                    report_mismatch("longest_length", got_len, want.length);
                if (got_ovf !== want.overflow)
                    report_mismatch("length_overflow", got_ovf, want.overflow);
            end
        end
        if (in_xfer || out_xfer || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer in %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Element driver: one transfer per queued item, with a drawn gap after each while src_idle_on is set.
    always @(negedge clk)
    begin
        element_t nxt;
        logic     valid_nxt;
        if (rst_n)
        begin
            valid_nxt = s_axis_tvalid && !in_xfer;
            if (in_xfer)
                src_gap = src_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (!valid_nxt)
            begin
                if (src_gap > 0)
                    src_gap--;
                else if (pending_q.size() != 0)
                begin
                    nxt           = pending_q.pop_front();
                    s_axis_tdata <= nxt.value;
                    s_axis_tlast <= nxt.last;
                    valid_nxt     = 1'b1;
                end
            end
            s_axis_tvalid <= valid_nxt;
        end
    end

    // Result receiver: stalls each offered result for a drawn number of cycles, and stalls on hold_req.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_xfer)
                snk_drawn = 1'b0;
            if (m_axis_tvalid && !snk_drawn)
            begin
                snk_wait  = snk_idle_on ? $urandom_range(0, MAX_GAP) : 0;
                snk_drawn = 1'b1;
            end
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (snk_wait > 0)
            begin
                snk_wait--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic push_item(input logic [lsdk_pkg::VALUE_W-1:0] value, input bit last);
        element_t e;
        e.value = value;
        e.last  = last;
        pending_q.push_back(e);
        if (last)
            arrays_queued++;
    endtask

    function automatic logic [lsdk_pkg::VALUE_W-1:0] draw_value(input int unsigned k);
        value_kind_t kind;
        int          ks;
        kind = value_kind_t'($urandom_range(0, 3));
        ks   = int'(k);
        case (kind)
            VK_FULL:     return $urandom;
            VK_SMALL:    return $urandom_range(0, 2 * k) - ks;
            VK_MULTIPLE: return ks * (int'($urandom_range(0, 2000)) - 1000);
            default:
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return '0;
                    default: return '1;
                endcase
        endcase
    endfunction

    task automatic push_array(input int len);
        for (int n = 0; n < len; n++)
            push_item(draw_value(eff_modulus()), n == len - 1);
    endtask

    function automatic int draw_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 88)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 24);
        return $urandom_range(25, 80);
    endfunction

    function automatic int unsigned pick_modulus();
        case ($urandom_range(0, 9))
            0:       return 1;
            1:       return 2;
            2:       return 3;
            3:       return 7;
            4:       return lsdk_pkg::MODULUS_MAX;
            5:       return lsdk_pkg::MODULUS_MAX - 1;
            6:       return $urandom_range(2, 64);
            7:       return $urandom_range(65, lsdk_pkg::MODULUS_MAX);
            8:       return $urandom_range(lsdk_pkg::MODULUS_MAX + 1,
                                           (1 << lsdk_pkg::MOD_W) - 1);
            default: return 0;
        endcase
    endfunction

    // Returns on a rising edge once nothing is queued, offered or outstanding.
    task automatic wait_drained();
        @(posedge clk);
        while (pending_q.size() != 0 || s_axis_tvalid || expected_spans.size() != 0)
            @(posedge clk);
    endtask

    // The block may still be folding an element with no result, so let it settle first.
    task automatic set_modulus(input int unsigned m);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m[lsdk_pkg::MOD_W-1:0];
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        mod_reg = m[lsdk_pkg::MOD_W-1:0];
        modulus_writes++;
        @(posedge clk);
    endtask

    initial
    begin
        int rand_items;
        int len;
        int arrays_in_phase;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Modulus is 1 out of reset, so the whole array is divisible.
        push_item(32'd5, 1'b0);
        push_item(32'hFFFF_FFFD, 1'b1);
        set_modulus(0);
        push_item(32'h7FFF_FFFF, 1'b1);
        // An all-ones write saturates to the largest modulus.
        set_modulus((1 << lsdk_pkg::MOD_W) - 1);
        push_item(32'h8000_0000, 1'b0);
        push_item(32'h7FFF_FFFF, 1'b0);
        push_item(32'd1, 1'b1);
        set_modulus(lsdk_pkg::MODULUS_MAX + 1);
        push_item(32'd1023, 1'b0);
        push_item(32'hFFFF_FFFF, 1'b0);
        push_item(32'd1024, 1'b1);
        set_modulus(7);
        push_item(32'd3, 1'b0);
        push_item(32'd4, 1'b0);
        push_item(32'd1, 1'b0);
        push_item(32'd6, 1'b0);
        push_item(32'd2, 1'b1);
        push_item(32'd1, 1'b0);
        push_item(32'd1, 1'b1);
        // The modulus moves while an array is half way through.
        push_item(32'd2, 1'b0);
        push_item(32'd3, 1'b0);
        set_modulus(5);
        push_item(32'd5, 1'b0);
        push_item(32'd1, 1'b1);
        set_modulus(lsdk_pkg::MODULUS_MAX);
        push_item(32'd1, 1'b1);

        // The receiver holds off while short arrays keep coming, so the input backs up.
        set_modulus(3);
        hold_req = 1'b1;
        for (int n = 0; n < 60; n++)
            push_array($urandom_range(1, 2));
        wait_drained();

        rand_items = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            set_modulus(pick_modulus());
            src_idle_on     = $urandom_range(0, 3) != 0;
            snk_idle_on     = $urandom_range(0, 3) != 0;
            arrays_in_phase = $urandom_range(5, 30);
            for (int n = 0; n < arrays_in_phase; n++)
            begin
                len = draw_length();
                push_array(len);
                rand_items += len;
            end
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_spans.size() != 0)
            report_mismatch("results never delivered", 0, expected_spans.size());
        $display("Covered %0d arrays, %0d elements and %0d results over %0d modulus writes,",
                 arrays_queued, elements_taken, results_checked, modulus_writes);
        $display("with out-of-range moduli, a modulus change inside an array and a long stall.");
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
src/lsdk_pkg.sv
src/lsdk_mod.sv
src/lsdk_table.sv
src/longest_subarray_sum_div_k.sv
sim/tb_longest_subarray_sum_div_k.sv
